[design/vrt_pkg.sv]
// shared types and constants of the voxel ray traversal unit
package vrt_pkg;

    localparam int DIST_W = 32;
    localparam logic [DIST_W-1:0] DIST_SAT = '1;

    localparam int EMPTY_W = 16;
    localparam int MAXD_W = 31;
    localparam logic [EMPTY_W-1:0] EMPTY_RESET = 16'hFFFF;
    localparam logic [MAXD_W-1:0] MAXD_RESET = 31'd6553600;

    localparam logic CFG_EMPTY = 1'b0;
    localparam logic CFG_MAXD = 1'b1;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_RAY = 1'b1;

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_DSTART = 7'b0000100,
        S_DWAIT  = 7'b0001000,
        S_READ   = 7'b0010000,
        S_CHECK  = 7'b0100000,
        S_DONE   = 7'b1000000
    } t_state;

endpackage

[design/voxel_ray_traversal_unit.sv]
// top level of the voxel ray traversal unit
// A write transaction stores a tile code in one cell of the grid; a ray
// transaction returns one result. A ray runs the setup of the three axes through one shared
// serial divider (six divisions, none for an axis with zero direction), then walks the cells,
// each through a tile memory read state and a check and step state, up to
// 4*(2*GRID_XY+GRID_Z)+8 steps. After reset a clearing pass over all GRID_XY*GRID_XY*GRID_Z
// cells (65536 with the defaults) fills the tile memory with 16'hFFFF, the reset empty code;
// no transaction is accepted until it ends, configuration writes are taken at any time. A
// finished result waits in the output register while the next transaction is accepted.
module voxel_ray_traversal_unit #(
    parameter int GRID_XY = 64,
    parameter int GRID_Z = 16,
    parameter int TILE_BITS = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic                                 i_cfg_index,
    input  logic [vrt_pkg::MAXD_W-1:0]           i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_action,
    input  logic [$clog2(GRID_XY)-1:0]           i_cell_x,
    input  logic [$clog2(GRID_XY)-1:0]           i_cell_y,
    input  logic [((GRID_Z > 1) ? $clog2(GRID_Z) : 1)-1:0] i_cell_z,
    input  logic [TILE_BITS-1:0]                 i_tile_code,
    input  logic signed [31:0]                   i_origin_x,
    input  logic signed [31:0]                   i_origin_y,
    input  logic signed [31:0]                   i_origin_z,
    input  logic signed [31:0]                   i_dir_x,
    input  logic signed [31:0]                   i_dir_y,
    input  logic signed [31:0]                   i_dir_z,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic                                 o_hit,
    output logic [TILE_BITS-1:0]                 o_hit_tile,
    output logic [$clog2(GRID_XY)-1:0]           o_hit_x,
    output logic [$clog2(GRID_XY)-1:0]           o_hit_y,
    output logic [((GRID_Z > 1) ? $clog2(GRID_Z) : 1)-1:0] o_hit_z
);
    import vrt_pkg::*;

    localparam int F = FRAC_BITS;
    localparam int XW = $clog2(GRID_XY);
    localparam int ZW = (GRID_Z > 1) ? $clog2(GRID_Z) : 1;
    localparam int CELLS = GRID_XY * GRID_XY * GRID_Z;
    localparam int AW = $clog2(CELLS);
    localparam int GMAX = (GRID_XY > GRID_Z) ? GRID_XY : GRID_Z;
    localparam int CW = $clog2(GMAX) + 2;
    localparam int NW = (2 * F + 1 > 33) ? 2 * F + 1 : 33;
    localparam int GUARD = 4 * (2 * GRID_XY + GRID_Z) + 8;
    localparam int GW = $clog2(GUARD + 1);
    localparam logic [TILE_BITS-1:0] TILE_FILL = TILE_BITS'(32'h0000_FFFF);

    t_state r_state;
    logic [EMPTY_W-1:0] r_empty;
    logic [MAXD_W-1:0]  r_maxd;
    logic [AW-1:0]      r_clr;

    logic [TILE_BITS-1:0] mem [CELLS];
    logic [TILE_BITS-1:0] r_rd;
    logic                 mem_we;
    logic [AW-1:0]        mem_wa;
    logic [TILE_BITS-1:0] mem_wd;
    logic [AW-1:0]        mem_ra;

    logic signed [31:0]   r_org [3];
    logic signed [31:0]   r_dir [3];
    logic signed [CW-1:0] r_cell [3];
    logic [DIST_W-1:0]    r_tmax [3];
    logic [DIST_W-1:0]    r_tdel [3];
    logic                 r_outside;
    logic [2:0]           r_job;
    logic [GW-1:0]        r_guard;

    logic                 r_p_hit;
    logic [TILE_BITS-1:0] r_p_tile;
    logic [XW-1:0]        r_p_x;
    logic [XW-1:0]        r_p_y;
    logic [ZW-1:0]        r_p_z;

    logic                 r_ov;
    logic                 r_o_hit;
    logic [TILE_BITS-1:0] r_o_tile;
    logic [XW-1:0]        r_o_x;
    logic [XW-1:0]        r_o_y;
    logic [ZW-1:0]        r_o_z;

    logic                 in_acc;
    logic [TILE_BITS-1:0] empty_m;
    logic signed [31:0]   org_in [3];
    logic signed [31:0]   c_full [3];
    logic                 c_out [3];

    logic [1:0]           job_ax;
    logic signed [31:0]   d_sel;
    logic                 d_neg;
    logic                 d_zero;
    logic [31:0]          d_abs;
    logic [F-1:0]         frac;
    logic [F:0]           one_m;
    logic [NW-1:0]        div_num;
    logic                 div_start;
    logic                 div_done;
    logic [NW-1:0]        div_quo;
    logic [DIST_W-1:0]    quo_sat;

    logic                 cell_in;
    logic [1:0]           ax;
    logic [DIST_W:0]      tsum;
    logic [DIST_W-1:0]    n_tmax;
    logic                 load_out;

    assign in_acc = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign empty_m = TILE_BITS'(r_empty);

    assign org_in[0] = i_origin_x;
    assign org_in[1] = i_origin_y;
    assign org_in[2] = i_origin_z;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            c_full[a] = org_in[a] >>> F;
            c_out[a] = (c_full[a] < 0) ||
                (c_full[a] >= ((a == 2) ? 32'(GRID_Z) : 32'(GRID_XY)));
        end
    end

    // per-axis divider operands
    always_comb begin
        job_ax = r_job[2:1];
        d_sel = r_dir[job_ax];
        d_neg = d_sel[31];
        d_zero = (d_sel == 0);
        d_abs = d_neg ? (~d_sel + 32'd1) : d_sel;
        frac = r_org[job_ax][F-1:0];
        one_m = {1'b1, {F{1'b0}}} - {1'b0, frac};
        if (r_job[0] == 1'b0) begin
            div_num = NW'({1'b1, {(2 * F){1'b0}}});
        end else if (d_neg) begin
            div_num = NW'({frac, {F{1'b0}}});
        end else begin
            div_num = NW'({one_m, {F{1'b0}}});
        end
        div_start = (r_state == S_DSTART) && !d_zero;
        quo_sat = (|div_quo[NW-1:DIST_W]) ? DIST_SAT : div_quo[DIST_W-1:0];
    end

    vrt_div #(
        .NW(NW),
        .DW(32)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (div_num),
        .i_den  (d_abs),
        .o_done (div_done),
        .o_quo  (div_quo)
    );

    // walk step selection
    always_comb begin
        cell_in = (r_cell[0] >= 0) && (r_cell[0] < CW'(GRID_XY)) &&
            (r_cell[1] >= 0) && (r_cell[1] < CW'(GRID_XY)) &&
            (r_cell[2] >= 0) && (r_cell[2] < CW'(GRID_Z));
        if (r_tmax[0] < r_tmax[1] && r_tmax[0] < r_tmax[2]) begin
            ax = 2'd0;
        end else if (r_tmax[1] < r_tmax[2]) begin
            ax = 2'd1;
        end else begin
            ax = 2'd2;
        end
        tsum = {1'b0, r_tmax[ax]} + {1'b0, r_tdel[ax]};
        n_tmax = tsum[DIST_W] ? DIST_SAT : tsum[DIST_W-1:0];
        mem_ra = AW'(32'(unsigned'(r_cell[0][CW-1:0])) * 32'(GRID_XY * GRID_Z) +
            32'(unsigned'(r_cell[1][CW-1:0])) * 32'(GRID_Z) +
            32'(unsigned'(r_cell[2][CW-1:0])));
    end

    // tile memory writes: clearing pass and write transactions
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_clr;
        mem_wd = TILE_FILL;
        if (r_state == S_CLEAR) begin
            mem_we = 1'b1;
        end else if (in_acc && i_action == ACT_WRITE) begin
            mem_we = (32'(i_cell_x) < 32'(GRID_XY)) && (32'(i_cell_y) < 32'(GRID_XY)) &&
                (32'(i_cell_z) < 32'(GRID_Z));
            mem_wa = AW'(32'(i_cell_x) * 32'(GRID_XY * GRID_Z) +
                32'(i_cell_y) * 32'(GRID_Z) + 32'(i_cell_z));
            mem_wd = i_tile_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd <= mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_empty <= EMPTY_RESET;
            r_maxd <= MAXD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_EMPTY: r_empty <= i_cfg_data[EMPTY_W-1:0];
                CFG_MAXD: r_maxd <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign load_out = (r_state == S_DONE) && (!r_ov || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr <= '0;
            r_job <= '0;
            r_guard <= '0;
            for (int a = 0; a < 3; a++) begin
                r_cell[a] <= '0;
                r_tmax[a] <= '0;
                r_tdel[a] <= '0;
            end
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(CELLS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc && i_action == ACT_RAY) begin
                        for (int a = 0; a < 3; a++) begin
                            r_cell[a] <= c_full[a][CW-1:0];
                        end
                        r_outside <= c_out[0] || c_out[1] || c_out[2];
                        r_job <= '0;
                        r_guard <= '0;
                        r_state <= S_DSTART;
                    end
                end
                S_DSTART: begin
                    if (d_zero) begin
                        r_tmax[job_ax] <= DIST_SAT;
                        r_tdel[job_ax] <= DIST_SAT;
                        if (r_job[2:1] == 2'd2) begin
                            r_state <= S_READ;
                        end
                        r_job <= {r_job[2:1] + 2'd1, 1'b0};
                    end else begin
                        r_state <= S_DWAIT;
                    end
                end
                S_DWAIT: begin
                    if (div_done) begin
                        if (r_job[0]) begin
                            r_tmax[job_ax] <= quo_sat;
                        end else begin
                            r_tdel[job_ax] <= quo_sat;
                        end
                        r_job <= r_job + 3'd1;
                        r_state <= (r_job == 3'd5) ? S_READ : S_DSTART;
                    end
                end
                S_READ: begin
                    r_p_hit <= 1'b0;
                    r_p_tile <= '0;
                    r_p_x <= '0;
                    r_p_y <= '0;
                    r_p_z <= '0;
                    if (r_outside || !cell_in || r_guard == GW'(GUARD)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (r_rd != empty_m) begin
                        r_p_hit <= 1'b1;
                        r_p_tile <= r_rd;
                        r_p_x <= r_cell[0][XW-1:0];
                        r_p_y <= r_cell[1][XW-1:0];
                        r_p_z <= r_cell[2][ZW-1:0];
                        r_state <= S_DONE;
                    end else if (r_tmax[ax] > {1'b0, r_maxd}) begin
                        r_state <= S_DONE;
                    end else begin
                        r_cell[ax] <= r_dir[ax][31] ? r_cell[ax] - CW'(1) : r_cell[ax] + CW'(1);
                        r_tmax[ax] <= n_tmax;
                        r_guard <= r_guard + GW'(1);
                        r_state <= S_READ;
                    end
                end
                S_DONE: begin
                    if (load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_action == ACT_RAY) begin
            r_org[0] <= i_origin_x;
            r_org[1] <= i_origin_y;
            r_org[2] <= i_origin_z;
            r_dir[0] <= i_dir_x;
            r_dir[1] <= i_dir_y;
            r_dir[2] <= i_dir_z;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (load_out) begin
            r_ov <= 1'b1;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_hit <= r_p_hit;
            r_o_tile <= r_p_tile;
            r_o_x <= r_p_x;
            r_o_y <= r_p_y;
            r_o_z <= r_p_z;
        end
    end

    assign o_out_valid = r_ov;
    assign o_hit = r_o_hit;
    assign o_hit_tile = r_o_tile;
    assign o_hit_x = r_o_x;
    assign o_hit_y = r_o_y;
    assign o_hit_z = r_o_z;
endmodule

[design/vrt_div.sv]
// serial restoring divider, one quotient bit per cycle
module vrt_div #(
    parameter int NW = 33,
    parameter int DW = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quo
);
    localparam int CNW = $clog2(NW + 1);

    logic           r_busy;
    logic           r_done;
    logic [CNW-1:0] r_cnt;
    logic [DW-1:0]  r_rem;
    logic [NW-1:0]  r_q;
    logic [DW-1:0]  r_den;
    logic [DW:0]    rem_sh;
    logic [DW:0]    rem_nx;
    logic           ge;
    logic [DW-1:0]  n_rem;

    always_comb begin
        rem_sh = {r_rem, r_q[NW-1]};
        ge = rem_sh >= {1'b0, r_den};
        rem_nx = ge ? rem_sh - {1'b0, r_den} : rem_sh;
        n_rem = rem_nx[DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= CNW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNW'(1);
                if (r_cnt == CNW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_q <= {r_q[NW-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo = r_q;
endmodule

[tb/tb_top.sv]
// testbench of the voxel ray traversal unit: tile writes, ray casts and register phases
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import vrt_pkg::*;

    localparam int GRID_XY = 64;
    localparam int GRID_Z = 16;
    localparam int WALK_GUARD = 4 * (2 * GRID_XY + GRID_Z) + 8;
    localparam int WATCHDOG_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic        hit;
        logic [15:0] tile;
        logic [5:0]  x;
        logic [5:0]  y;
        logic [3:0]  z;
    } t_hit;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_index = CFG_EMPTY;
    logic [MAXD_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic action = ACT_WRITE;
    logic [5:0] cell_x = '0;
    logic [5:0] cell_y = '0;
    logic [3:0] cell_z = '0;
    logic [15:0] tile_code = '0;
    logic signed [31:0] origin_x = '0, origin_y = '0, origin_z = '0;
    logic signed [31:0] dir_x = '0, dir_y = '0, dir_z = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic hit;
    logic [15:0] hit_tile;
    logic [5:0] hit_x, hit_y;
    logic [3:0] hit_z;

    logic [15:0] tile_grid [GRID_XY*GRID_XY*GRID_Z];
    logic [EMPTY_W-1:0] empty_setting = EMPTY_RESET;
    logic [MAXD_W-1:0] dist_limit = MAXD_RESET;
    t_hit pending_hits[$];
    bit quiet = 1'b0;
    int mismatches = 0;
    int rays_sent = 0;
    int writes_sent = 0;
    int hits_seen = 0;
    int results_seen = 0;
    int idle_cycles = 0;

    always #6 clk = ~clk;

    voxel_ray_traversal_unit i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_action(action), .i_cell_x(cell_x), .i_cell_y(cell_y), .i_cell_z(cell_z),
        .i_tile_code(tile_code),
        .i_origin_x(origin_x), .i_origin_y(origin_y), .i_origin_z(origin_z),
        .i_dir_x(dir_x), .i_dir_y(dir_y), .i_dir_z(dir_z),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_hit(hit), .o_hit_tile(hit_tile), .o_hit_x(hit_x), .o_hit_y(hit_y), .o_hit_z(hit_z)
    );

    function automatic int grid_addr(longint x, longint y, longint z);
        return int'((x * GRID_XY + y) * GRID_Z + z);
    endfunction

    function automatic logic [31:0] div_sat(longint unsigned num, longint unsigned den);
        longint unsigned q;
        q = num / den;
        return (q > 64'hFFFF_FFFF) ? DIST_SAT : q[31:0];
    endfunction

    function automatic t_hit trace_ray(logic signed [31:0] org [3], logic signed [31:0] dir [3]);
        longint pos [3];
        longint step [3];
        logic [31:0] tmax [3];
        logic [31:0] tdelta [3];
        longint o, d, frac;
        longint unsigned ad, num, sum;
        t_hit r;
        int ax;
        r = '0;
        for (int a = 0; a < 3; a++) begin
            o = longint'(org[a]);
            d = longint'(dir[a]);
            pos[a] = o >>> 16;
            frac = o & 64'hFFFF;
            if (d == 0) begin
                step[a] = 0;
                tmax[a] = DIST_SAT;
                tdelta[a] = DIST_SAT;
            end else begin
                ad = (d > 0) ? d : -d;
                num = (d > 0) ? (65536 - frac) : frac;
                step[a] = (d > 0) ? 1 : -1;
                tmax[a] = div_sat(num << 16, ad);
                tdelta[a] = div_sat(64'd1 << 32, ad);
            end
        end
        for (int g = 0; g < WALK_GUARD; g++) begin
            if (pos[0] < 0 || pos[0] >= GRID_XY || pos[1] < 0 || pos[1] >= GRID_XY ||
                pos[2] < 0 || pos[2] >= GRID_Z) begin
                break;
            end
            if (tile_grid[grid_addr(pos[0], pos[1], pos[2])] != empty_setting) begin
                r.hit = 1'b1;
                r.tile = tile_grid[grid_addr(pos[0], pos[1], pos[2])];
                r.x = pos[0][5:0];
                r.y = pos[1][5:0];
                r.z = pos[2][3:0];
                break;
            end
            if (tmax[0] < tmax[1] && tmax[0] < tmax[2]) ax = 0;
            else if (tmax[1] < tmax[2]) ax = 1;
            else ax = 2;
            if (tmax[ax] > {1'b0, dist_limit}) break;
            pos[ax] += step[ax];
            sum = longint'(tmax[ax]) + longint'(tdelta[ax]);
            tmax[ax] = (sum > 64'hFFFF_FFFF) ? DIST_SAT : sum[31:0];
        end
        return r;
    endfunction

    // input side idle gap, valid held low while idling
    task automatic input_gap();
        if (!quiet && $urandom_range(99) < 8) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic send_transaction(logic act, logic [5:0] cx, logic [5:0] cy, logic [3:0] cz,
                                    logic [15:0] code, logic signed [31:0] org [3],
                                    logic signed [31:0] dir [3]);
        input_gap();
        in_valid <= 1'b1;
        action <= act;
        cell_x <= cx;
        cell_y <= cy;
        cell_z <= cz;
        tile_code <= code;
        origin_x <= org[0];
        origin_y <= org[1];
        origin_z <= org[2];
        dir_x <= dir[0];
        dir_y <= dir[1];
        dir_z <= dir[2];
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (act == ACT_WRITE) begin
            tile_grid[grid_addr(longint'(cx), longint'(cy), longint'(cz))] = code;
            writes_sent++;
        end else begin
            pending_hits.push_back(trace_ray(org, dir));
            rays_sent++;
        end
    endtask

    task automatic write_tile(logic [5:0] cx, logic [5:0] cy, logic [3:0] cz, logic [15:0] code);
        logic signed [31:0] zv [3];
        zv = '{default: '0};
        send_transaction(ACT_WRITE, cx, cy, cz, code, zv, zv);
    endtask

    task automatic cast_ray(logic signed [31:0] org [3], logic signed [31:0] dir [3]);
        send_transaction(ACT_RAY, 6'($urandom), 6'($urandom), 4'($urandom), 16'($urandom),
                         org, dir);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_hits.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic idx, logic [MAXD_W-1:0] value);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_EMPTY) empty_setting = value[EMPTY_W-1:0];
        else dist_limit = value;
    endtask

    function automatic logic signed [31:0] rand_origin(int cells);
        if ($urandom_range(99) < 6) return $urandom;
        return {16'($urandom_range(cells - 1)), 16'($urandom)};
    endfunction

    function automatic logic signed [31:0] rand_dir();
        int pick;
        logic signed [31:0] v;
        pick = $urandom_range(99);
        if (pick < 10) return '0;
        if (pick < 20) return $urandom;
        v = $urandom_range(1, 32'h0002_0000);
        return $urandom_range(1) ? -v : v;
    endfunction

    task automatic random_ray();
        logic signed [31:0] org [3];
        logic signed [31:0] dir [3];
        org[0] = rand_origin(GRID_XY);
        org[1] = rand_origin(GRID_XY);
        org[2] = rand_origin(GRID_Z);
        dir[0] = rand_dir();
        dir[1] = rand_dir();
        dir[2] = rand_dir();
        cast_ray(org, dir);
    endtask

    task automatic random_item();
        logic [15:0] code;
        if ($urandom_range(99) < 45) begin
            code = ($urandom_range(9) == 0) ? empty_setting : 16'($urandom);
            write_tile(6'($urandom), 6'($urandom), 4'($urandom), code);
        end else begin
            random_ray();
        end
    endtask

    task automatic test_directed();
        logic signed [31:0] org [3];
        logic signed [31:0] dir [3];
        write_tile(6'd0, 6'd0, 4'd0, 16'h1234);
        write_tile(6'd63, 6'd63, 4'd15, 16'h0000);
        write_tile(6'd10, 6'd20, 4'd5, 16'hFFFE);
        org = '{32'h0000_8000, 32'h0000_8000, 32'h0000_8000};
        dir = '{32'h0001_0000, 32'h0, 32'h0};
        cast_ray(org, dir);
        org = '{32'h003F_8000, 32'h0030_0000, 32'h000F_8000};
        dir = '{32'h0, 32'h0001_0000, 32'h0};
        cast_ray(org, dir);
        org = '{32'h000A_8000, 32'h0000_8000, 32'h0005_8000};
        dir = '{32'h0, 32'h0001_0000, 32'h0};
        cast_ray(org, dir);
        org = '{32'hFFFF_8000, 32'h0000_8000, 32'h0000_8000};
        cast_ray(org, dir);
        org = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000};
        cast_ray(org, dir);
        org = '{32'h0020_0000, 32'h0020_0000, 32'h0008_0000};
        dir = '{32'h0, 32'h0, 32'h0};
        cast_ray(org, dir);
        dir = '{32'h0001_0000, 32'h0001_0000, 32'h0001_0000};
        cast_ray(org, dir);
        dir = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF};
        cast_ray(org, dir);
        dir = '{32'h0000_0001, 32'hFFFF_FFFF, 32'h0};
        cast_ray(org, dir);
        org = '{32'h0001_0000, 32'h0001_0000, 32'h0001_0000};
        dir = '{32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000};
        cast_ray(org, dir);
        write_tile(6'd0, 6'd0, 4'd0, 16'hFFFF);
        cast_ray(org, dir);
        write_tile(6'd63, 6'd63, 4'd15, 16'hFFFF);
        org = '{32'h003F_FFFF, 32'h003F_FFFF, 32'h000F_FFFF};
        dir = '{32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000};
        cast_ray(org, dir);
    endtask

    task automatic test_register_extremes();
        write_register(CFG_EMPTY, '0);
        write_register(CFG_MAXD, '0);
        repeat (20) random_item();
        write_register(CFG_MAXD, '1);
        repeat (20) random_item();
        write_register(CFG_EMPTY, MAXD_W'(EMPTY_RESET));
        repeat (20) random_item();
    endtask

    task automatic test_random(int count, bit no_idle);
        quiet = no_idle;
        repeat (count) random_item();
        quiet = 1'b0;
    endtask

    always @(posedge clk) begin
        out_stall <= !quiet && ($urandom_range(99) < 8);
    end

    always @(posedge clk) begin
        t_hit want;
        if (rst_n && out_valid && !out_stall) begin
            results_seen++;
            if (hit) hits_seen++;
            if (pending_hits.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transaction hit=%0b", hit);
            end else begin
                want = pending_hits.pop_front();
                if (hit !== want.hit || hit_tile !== want.tile || hit_x !== want.x ||
                    hit_y !== want.y || hit_z !== want.z) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected hit=%0b tile=%h cell=(%0d,%0d,%0d) got hit=%0b tile=%h cell=(%0d,%0d,%0d)",
                                 want.hit, want.tile, want.x, want.y, want.z,
                                 hit, hit_tile, hit_x, hit_y, hit_z);
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog timeout with %0d results outstanding", pending_hits.size());
            $display("voxel_ray_traversal_unit verification failed");
            $finish;
        end
    end

    initial begin
        foreach (tile_grid[i]) tile_grid[i] = EMPTY_RESET;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_register_extremes();
        test_random(250, 1'b1);
        write_register(CFG_MAXD, 31'h0014_0000);
        test_random(230, 1'b0);
        write_register(CFG_EMPTY, 31'h0000_0000);
        write_register(CFG_MAXD, 31'h0200_0000);
        test_random(230, 1'b0);
        write_register(CFG_EMPTY, 31'h0000_ABCD);
        test_random(230, 1'b0);
        write_register(CFG_EMPTY, MAXD_W'(EMPTY_RESET));
        write_register(CFG_MAXD, MAXD_RESET);
        test_random(230, 1'b0);
        wait_drained();
        $display("covered %0d tile writes and %0d rays, %0d results of which %0d hits",
                 writes_sent, rays_sent, results_seen, hits_seen);
        $display("register phases included zero and full-scale limits, %0d mismatches",
                 mismatches);
        if (mismatches == 0) begin
            $display("voxel_ray_traversal_unit verification clean");
        end else begin
            $display("voxel_ray_traversal_unit verification failed");
        end
        $finish;
    end
endmodule
